FILE: hw/rtl/tust_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tust_pkg: shared types and codes of the tagged usage statistics table
// Holds the operation and status codes, the field widths of the item channels
// and the control word that travels down the cell chain.
// ----------------------------------------------------------------------------
package tust_pkg;

    localparam int OP_W   = 3;
    localparam int TAG_W  = 16;
    localparam int SIZE_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_QRY_TAG = 3'd2,
        OP_QRY_GLB = 3'd3,
        OP_CLR_TAB = 3'd4,
        OP_CLR_GLB = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNTAGGED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Control word of one item walking the chain
    typedef struct packed {
        logic vld;    // token present
        logic upd;    // allocate or free on a nonzero tag, tracking on
        logic qry;    // tag query on a nonzero tag
        logic clr;    // clear the whole table
        logic alloc;  // allocate (else free) when upd
        logic hit;    // a cell already served the item
    } t_ctl;

endpackage

FILE: hw/rtl/tust_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tust_req_if: request item channel
// Valid/ready channel carrying op, tag and byte size.
// ----------------------------------------------------------------------------
interface tust_req_if;
    logic                          valid;
    logic                          ready;
    logic [tust_pkg::OP_W-1:0]     op;
    logic [tust_pkg::TAG_W-1:0]    tag;
    logic [tust_pkg::SIZE_W-1:0]   size_bytes;

    modport source (output valid, output op, output tag, output size_bytes, input ready);
    modport sink   (input valid, input op, input tag, input size_bytes, output ready);
endinterface

FILE: hw/rtl/tust_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tust_rsp_if: result item channel
// Valid/ready channel carrying status and the four counters.
// ----------------------------------------------------------------------------
interface tust_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tust_pkg::STAT_W-1:0]   status;
    logic [tust_pkg::CNT_W-1:0]    current_bytes;
    logic [tust_pkg::CNT_W-1:0]    peak_bytes;
    logic [tust_pkg::CNT_W-1:0]    alloc_events;
    logic [tust_pkg::CNT_W-1:0]    free_events;

    modport source (output valid, output status, output current_bytes, output peak_bytes,
                    output alloc_events, output free_events, input ready);
    modport sink   (input valid, input status, input current_bytes, input peak_bytes,
                    input alloc_events, input free_events, output ready);
endinterface

FILE: hw/rtl/tust_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tust_cell: one slot of the per-tag table
// Holds one tag and its four counters; serves the passing item when the tag
// matches, or claims the slot for an allocate when it is unused, then hands the item on.
// ----------------------------------------------------------------------------
module tust_cell #(
    parameter int TAG_BITS   = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tust_pkg::t_ctl                i_ctl,
    input  logic [TAG_BITS-1:0]           i_tag,
    input  logic [COUNT_BITS-1:0]         i_size,
    input  logic [tust_pkg::STAT_W-1:0]   i_status,
    input  logic [COUNT_BITS-1:0]         i_cur,
    input  logic [COUNT_BITS-1:0]         i_peak,
    input  logic [COUNT_BITS-1:0]         i_alc,
    input  logic [COUNT_BITS-1:0]         i_fre,
    output tust_pkg::t_ctl                o_ctl,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic [COUNT_BITS-1:0]         o_size,
    output logic [tust_pkg::STAT_W-1:0]   o_status,
    output logic [COUNT_BITS-1:0]         o_cur,
    output logic [COUNT_BITS-1:0]         o_peak,
    output logic [COUNT_BITS-1:0]         o_alc,
    output logic [COUNT_BITS-1:0]         o_fre
);

    logic [TAG_BITS-1:0]   r_tag, n_tag;
    logic [COUNT_BITS-1:0] r_cur, n_cur, r_peak, n_peak, r_alc, n_alc, r_fre, n_fre;
    tust_pkg::t_ctl        r_ctl, n_ctl;
    logic [TAG_BITS-1:0]   r_otag;
    logic [COUNT_BITS-1:0] r_osize, r_ocur, r_opeak, r_oalc, r_ofre;
    logic [tust_pkg::STAT_W-1:0] r_ostat;
    logic [COUNT_BITS-1:0] n_ocur, n_opeak, n_oalc, n_ofre;
    logic [tust_pkg::STAT_W-1:0] n_ostat;
    logic                  w_live, w_match, w_claim, w_serve;

    // Used slots always form a prefix, so reaching an unused slot means a miss
    assign w_live  = i_ctl.vld && !i_ctl.hit;
    assign w_match = w_live && (i_ctl.upd || i_ctl.qry) && (r_tag == i_tag) && (r_tag != '0);
    assign w_claim = w_live && i_ctl.upd && i_ctl.alloc && (r_tag == '0);
    assign w_serve = w_match || w_claim;

    always_comb begin
        n_tag   = r_tag;
        n_cur   = r_cur;
        n_peak  = r_peak;
        n_alc   = r_alc;
        n_fre   = r_fre;
        n_ctl   = i_ctl;
        n_ostat = i_status;
        n_ocur  = i_cur;
        n_opeak = i_peak;
        n_oalc  = i_alc;
        n_ofre  = i_fre;
        if (i_ctl.vld && i_ctl.clr) begin
            n_tag  = '0;
            n_cur  = '0;
            n_peak = '0;
            n_alc  = '0;
            n_fre  = '0;
        end else if (w_serve) begin
            if (w_claim) begin
                n_tag  = i_tag;
                n_cur  = '0;
                n_peak = '0;
                n_alc  = '0;
                n_fre  = '0;
            end
            if (i_ctl.upd) begin
                if (i_ctl.alloc) begin
                    n_cur  = n_cur + i_size;
                    n_alc  = n_alc + COUNT_BITS'(1);
                    if (n_cur > n_peak) begin
                        n_peak = n_cur;
                    end
                end else begin
                    n_cur = n_cur - i_size;
                    n_fre = n_fre + COUNT_BITS'(1);
                end
            end
            n_ctl.hit = 1'b1;
            n_ostat   = tust_pkg::ST_OK;
            n_ocur    = n_cur;
            n_opeak   = n_peak;
            n_oalc    = n_alc;
            n_ofre    = n_fre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_cur  <= '0;
            r_peak <= '0;
            r_alc  <= '0;
            r_fre  <= '0;
            r_ctl  <= '0;
        end else begin
            r_tag  <= n_tag;
            r_cur  <= n_cur;
            r_peak <= n_peak;
            r_alc  <= n_alc;
            r_fre  <= n_fre;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_otag  <= i_tag;
        r_osize <= i_size;
        r_ostat <= n_ostat;
        r_ocur  <= n_ocur;
        r_opeak <= n_opeak;
        r_oalc  <= n_oalc;
        r_ofre  <= n_ofre;
    end

    assign o_ctl    = r_ctl;
    assign o_tag    = r_otag;
    assign o_size   = r_osize;
    assign o_status = r_ostat;
    assign o_cur    = r_ocur;
    assign o_peak   = r_opeak;
    assign o_alc    = r_oalc;
    assign o_fre    = r_ofre;

endmodule

FILE: hw/rtl/tagged_usage_stats_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_usage_stats_table: allocation statistics per tag and in total
// Counts allocate and free events globally and in a table of per-tag slots,
// and answers tag and global queries.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An accepted item updates the global
// counters at the accept edge and then walks a chain of NUM_SLOTS cells, one
// cell per cycle, from the entry register through the cells to the output
// register that holds its result. The next item is accepted once the result
// has been taken. A new tag claims the lowest unused slot; since slots are
// only released by a table clear, used slots stay packed at the head of the
// chain and a single pass both finds and claims. Writing tracking_enable low
// makes allocate and free items leave all counters alone; queries keep
// working. Counters wrap at 2^COUNT_BITS.
// ----------------------------------------------------------------------------
module tagged_usage_stats_table #(
    parameter int NUM_SLOTS  = 32,
    parameter int TAG_BITS   = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    tust_req_if.sink     i_req,
    tust_rsp_if.source   o_rsp
);

    localparam int OW = tust_pkg::CNT_W;

    logic                  r_trk;
    logic                  r_busy;
    logic [COUNT_BITS-1:0] r_tc, r_tp, r_ta, r_tf;
    logic [COUNT_BITS-1:0] n_tc, n_tp, n_ta, n_tf;

    // chain taps: index 0 is the entry register, index NUM_SLOTS the last cell
    tust_pkg::t_ctl                w_ctl  [0:NUM_SLOTS];
    logic [TAG_BITS-1:0]           w_tag  [0:NUM_SLOTS];
    logic [COUNT_BITS-1:0]         w_size [0:NUM_SLOTS];
    logic [tust_pkg::STAT_W-1:0]   w_stat [0:NUM_SLOTS];
    logic [COUNT_BITS-1:0]         w_cur  [0:NUM_SLOTS];
    logic [COUNT_BITS-1:0]         w_peak [0:NUM_SLOTS];
    logic [COUNT_BITS-1:0]         w_alc  [0:NUM_SLOTS];
    logic [COUNT_BITS-1:0]         w_fre  [0:NUM_SLOTS];

    tust_pkg::t_ctl                r_ectl, n_ectl;
    logic [TAG_BITS-1:0]           r_etag;
    logic [COUNT_BITS-1:0]         r_esize;
    logic [tust_pkg::STAT_W-1:0]   r_estat, n_estat;
    logic [COUNT_BITS-1:0]         r_ecur, r_epeak, r_ealc, r_efre;
    logic [COUNT_BITS-1:0]         n_ecur, n_epeak, n_ealc, n_efre;

    logic                          r_ovld;
    logic [tust_pkg::STAT_W-1:0]   r_ostat;
    logic [OW-1:0]                 r_ocur, r_opeak, r_oalc, r_ofre;

    logic                  w_acc, w_oacc;
    logic [TAG_BITS-1:0]   w_itag;
    logic [COUNT_BITS-1:0] w_isize;

    assign i_req.ready = !r_busy;
    assign w_acc  = i_req.valid && !r_busy;
    assign w_oacc = r_ovld && o_rsp.ready;
    assign w_itag  = TAG_BITS'(i_req.tag);
    assign w_isize = COUNT_BITS'(i_req.size_bytes);

    // Global update and the token that enters the chain
    always_comb begin
        n_tc    = r_tc;
        n_tp    = r_tp;
        n_ta    = r_ta;
        n_tf    = r_tf;
        n_ectl  = '0;
        n_estat = tust_pkg::ST_OK;
        n_ecur  = '0;
        n_epeak = '0;
        n_ealc  = '0;
        n_efre  = '0;
        n_ectl.vld = w_acc;
        unique case (tust_pkg::t_op'(i_req.op))
            tust_pkg::OP_ALLOC, tust_pkg::OP_FREE: begin
                if (r_trk) begin
                    if (i_req.op == tust_pkg::OP_ALLOC) begin
                        n_tc = r_tc + w_isize;
                        n_ta = r_ta + COUNT_BITS'(1);
                        if (n_tc > r_tp) begin
                            n_tp = n_tc;
                        end
                    end else begin
                        n_tc = r_tc - w_isize;
                        n_tf = r_tf + COUNT_BITS'(1);
                    end
                end
                // the miss answer carries the global counters
                n_ecur  = n_tc;
                n_epeak = n_tp;
                n_ealc  = n_ta;
                n_efre  = n_tf;
                if (!r_trk || w_itag == '0) begin
                    n_estat = tust_pkg::ST_UNTAGGED;
                end else begin
                    n_ectl.upd   = 1'b1;
                    n_ectl.alloc = (i_req.op == tust_pkg::OP_ALLOC);
                    n_estat = (i_req.op == tust_pkg::OP_ALLOC) ? tust_pkg::ST_FULL
                                                               : tust_pkg::ST_NOT_FOUND;
                end
            end
            tust_pkg::OP_QRY_TAG: begin
                if (w_itag == '0) begin
                    n_estat = tust_pkg::ST_UNTAGGED;
                end else begin
                    n_ectl.qry = 1'b1;
                    n_estat    = tust_pkg::ST_NOT_FOUND;
                end
            end
            tust_pkg::OP_QRY_GLB: begin
                n_ecur  = r_tc;
                n_epeak = r_tp;
                n_ealc  = r_ta;
                n_efre  = r_tf;
            end
            tust_pkg::OP_CLR_TAB: begin
                n_ectl.clr = 1'b1;
            end
            tust_pkg::OP_CLR_GLB: begin
                n_tc = '0;
                n_tp = '0;
                n_ta = '0;
                n_tf = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk  <= 1'b1;
            r_busy <= 1'b0;
            r_tc   <= '0;
            r_tp   <= '0;
            r_ta   <= '0;
            r_tf   <= '0;
            r_ectl <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_trk <= i_cfg_wdata;
            end
            // hold busy from accept until the result is taken
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_oacc) begin
                r_busy <= 1'b0;
            end
            if (w_acc) begin
                r_tc <= n_tc;
                r_tp <= n_tp;
                r_ta <= n_ta;
                r_tf <= n_tf;
            end
            r_ectl <= n_ectl;
            if (w_ctl[NUM_SLOTS].vld) begin
                r_ovld <= 1'b1;
            end else if (w_oacc) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_etag  <= w_itag;
        r_esize <= w_isize;
        r_estat <= n_estat;
        r_ecur  <= n_ecur;
        r_epeak <= n_epeak;
        r_ealc  <= n_ealc;
        r_efre  <= n_efre;
        if (w_ctl[NUM_SLOTS].vld) begin
            r_ostat <= w_stat[NUM_SLOTS];
            r_ocur  <= OW'(w_cur[NUM_SLOTS]);
            r_opeak <= OW'(w_peak[NUM_SLOTS]);
            r_oalc  <= OW'(w_alc[NUM_SLOTS]);
            r_ofre  <= OW'(w_fre[NUM_SLOTS]);
        end
    end

    assign w_ctl[0]  = r_ectl;
    assign w_tag[0]  = r_etag;
    assign w_size[0] = r_esize;
    assign w_stat[0] = r_estat;
    assign w_cur[0]  = r_ecur;
    assign w_peak[0] = r_epeak;
    assign w_alc[0]  = r_ealc;
    assign w_fre[0]  = r_efre;

    // Slot chain: advance the item one cell per cycle
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        tust_cell #(
            .TAG_BITS   (TAG_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_tag    (w_tag[g]),
            .i_size   (w_size[g]),
            .i_status (w_stat[g]),
            .i_cur    (w_cur[g]),
            .i_peak   (w_peak[g]),
            .i_alc    (w_alc[g]),
            .i_fre    (w_fre[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_tag    (w_tag[g+1]),
            .o_size   (w_size[g+1]),
            .o_status (w_stat[g+1]),
            .o_cur    (w_cur[g+1]),
            .o_peak   (w_peak[g+1]),
            .o_alc    (w_alc[g+1]),
            .o_fre    (w_fre[g+1])
        );
    end

    assign o_rsp.valid         = r_ovld;
    assign o_rsp.status        = r_ostat;
    assign o_rsp.current_bytes = r_ocur;
    assign o_rsp.peak_bytes    = r_opeak;
    assign o_rsp.alloc_events  = r_oalc;
    assign o_rsp.free_events   = r_ofre;

endmodule

FILE: hw/rtl/tust_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tust_checker: port-level checks of the usage statistics table
// Watches the two item channels for one-at-a-time ordering and held results.
// ----------------------------------------------------------------------------
module tust_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // an accepted item closes the input until its result is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input open right after accept");

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input open while a result waits");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> !i_out_valid)
        else $error("second result without a new item");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("stalled result dropped");

endmodule

bind tagged_usage_stats_table tust_checker u_tust_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready)
);
